@@ design/lrc_ts_pkg.sv @@
// Shared types, character codes and helpers for the lyric timestamp line parser.
package lrc_ts_pkg;

  // Line length limit and position width
  localparam int unsigned MaxLineBytes = 512;
  localparam int unsigned PosW         = $clog2(MaxLineBytes);
  localparam logic [PosW-1:0] PosLast  = PosW'(MaxLineBytes - 2);

  // Width of one numeric part and its saturation value
  localparam int unsigned PartW = 16;
  localparam logic [PartW-1:0] PartMax = '1;

  // Millisecond weights
  localparam logic [31:0] MsPerMin  = 32'd60000;
  localparam logic [31:0] MsPerSec  = 32'd1000;
  localparam logic [31:0] MsPerHund = 32'd10;

  // Character codes
  localparam logic [7:0] ChOpen  = 8'h5B;  // '['
  localparam logic [7:0] ChClose = 8'h5D;  // ']'
  localparam logic [7:0] ChColon = 8'h3A;  // ':'
  localparam logic [7:0] ChDot   = 8'h2E;  // '.'
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  // Input beat
  typedef struct packed {
    logic [7:0] line_byte;
    logic       line_end;
  } lrc_ts_in_t;

  // Result beat
  typedef struct packed {
    logic [31:0]     stamp_ms;
    logic            has_stamp;
    logic            is_metadata;
    logic [PosW-1:0] text_start;
    logic [PosW-1:0] line_length;
  } lrc_ts_out_t;

  // Line summary from the parser, stamp still in parts
  typedef struct packed {
    logic [PartW-1:0] min_part;
    logic [PartW-1:0] sec_part;
    logic [PartW-1:0] hund_part;
    logic             has_stamp;
    logic             is_metadata;
    logic [PosW-1:0]  text_start;
    logic [PosW-1:0]  line_length;
  } lrc_ts_sum_t;

  // Append one decimal digit, saturating at PartMax
  function automatic logic [PartW-1:0] acc_digit(logic [PartW-1:0] acc, logic [3:0] d);
    logic [PartW+3:0] v;
    v = (PartW+4)'(acc) * (PartW+4)'(10) + (PartW+4)'(d);
    return (v > (PartW+4)'(PartMax)) ? PartMax : v[PartW-1:0];
  endfunction

endpackage

@@ design/lrc_ts_parser.sv @@
// Per-byte stamp grammar walker; emits a line summary on the last byte.
module lrc_ts_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   beat_i,
  input  lrc_ts_pkg::lrc_ts_in_t data_i,
  output logic                   sum_valid_o,
  output lrc_ts_pkg::lrc_ts_sum_t sum_o
);

  typedef enum logic [6:0] {
    PhBracket  = 7'b0000001,
    PhMinFirst = 7'b0000010,
    PhMin      = 7'b0000100,
    PhSec      = 7'b0001000,
    PhHund     = 7'b0010000,
    PhBlanks   = 7'b0100000,
    PhText     = 7'b1000000
  } lrc_ts_phase_e;

  localparam int unsigned PW = lrc_ts_pkg::PosW;
  localparam int unsigned AW = lrc_ts_pkg::PartW;

  lrc_ts_phase_e phase_q, phase_d;
  logic [AW-1:0] min_q, min_d, sec_q, sec_d, hund_q, hund_d;
  logic [AW-1:0] fmin_q, fmin_d, fsec_q, fsec_d, fhund_q, fhund_d;
  logic          seen_q, seen_d;
  logic [PW-1:0] pos_q, pos_d, att_q, att_d, toff_q, toff_d;
  logic          opens_q, opens_d;

  logic [7:0]    b;
  logic          digit, blank, last, fail, done;
  logic [3:0]    dval;
  logic [PW-1:0] pos_inc;
  logic [PW-1:0] end_toff;
  logic          end_opens;

  assign b       = data_i.line_byte;
  assign digit   = (b >= lrc_ts_pkg::ChZero) && (b <= lrc_ts_pkg::ChNine);
  assign blank   = (b == lrc_ts_pkg::ChSpace) || (b == lrc_ts_pkg::ChTab);
  assign dval    = digit ? b[3:0] : 4'd0;
  assign pos_inc = pos_q + PW'(1);
  // long lines close on their last allowed byte
  assign last    = data_i.line_end || (pos_q == lrc_ts_pkg::PosLast);

  // Grammar step
  always_comb begin
    phase_d = phase_q;
    min_d   = min_q;
    sec_d   = sec_q;
    hund_d  = hund_q;
    att_d   = att_q;
    toff_d  = toff_q;
    opens_d = opens_q;
    fail    = 1'b0;
    done    = 1'b0;
    case (phase_q)
      PhBracket: begin
        if (b == lrc_ts_pkg::ChOpen) begin
          min_d   = '0;
          sec_d   = '0;
          hund_d  = '0;
          phase_d = PhMinFirst;
        end else if (blank) begin
          toff_d  = pos_inc;
          phase_d = PhBlanks;
        end else begin
          toff_d  = pos_q;
          phase_d = PhText;
        end
      end
      PhMinFirst: begin
        if (digit) begin
          min_d   = AW'(dval);
          phase_d = PhMin;
        end else begin
          fail = 1'b1;
        end
      end
      PhMin: begin
        if (digit) min_d = lrc_ts_pkg::acc_digit(min_q, dval);
        else if (b == lrc_ts_pkg::ChColon) phase_d = PhSec;
        else fail = 1'b1;
      end
      PhSec: begin
        if (digit) sec_d = lrc_ts_pkg::acc_digit(sec_q, dval);
        else if (b == lrc_ts_pkg::ChDot || b == lrc_ts_pkg::ChColon) phase_d = PhHund;
        else if (b == lrc_ts_pkg::ChClose) done = 1'b1;
        else fail = 1'b1;
      end
      PhHund: begin
        if (digit) hund_d = lrc_ts_pkg::acc_digit(hund_q, dval);
        else if (b == lrc_ts_pkg::ChClose) done = 1'b1;
        else fail = 1'b1;
      end
      PhBlanks: begin
        if (blank) toff_d = pos_inc;
        else phase_d = PhText;
      end
      default: phase_d = PhText;
    endcase

    // failed attempt: text starts at its '['
    if (fail) begin
      toff_d  = att_q;
      opens_d = 1'b1;
      phase_d = PhText;
    end

    // closed stamp: keep only the first one
    fmin_d  = fmin_q;
    fsec_d  = fsec_q;
    fhund_d = fhund_q;
    seen_d  = seen_q;
    if (done) begin
      if (!seen_q) begin
        fmin_d  = min_q;
        fsec_d  = sec_q;
        fhund_d = hund_q;
      end
      seen_d  = 1'b1;
      att_d   = pos_inc;
      phase_d = PhBracket;
    end
    pos_d = pos_inc;
  end

  // Line-end fixups and summary
  always_comb begin
    end_toff  = toff_d;
    end_opens = opens_d;
    if (phase_d == PhBracket) begin
      end_toff  = att_d;
      end_opens = 1'b0;
    end else if (phase_d inside {PhMinFirst, PhMin, PhSec, PhHund}) begin
      end_toff  = att_d;
      end_opens = 1'b1;
    end
    sum_valid_o       = beat_i && last;
    sum_o.min_part    = seen_d ? fmin_d  : '0;
    sum_o.sec_part    = seen_d ? fsec_d  : '0;
    sum_o.hund_part   = seen_d ? fhund_d : '0;
    sum_o.has_stamp   = seen_d;
    sum_o.is_metadata = !seen_d && end_opens;
    sum_o.text_start  = end_toff;
    sum_o.line_length = pos_d;
  end

  // State registers; cleared at every line end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhBracket;
      min_q   <= '0;
      sec_q   <= '0;
      hund_q  <= '0;
      fmin_q  <= '0;
      fsec_q  <= '0;
      fhund_q <= '0;
      seen_q  <= 1'b0;
      pos_q   <= '0;
      att_q   <= '0;
      toff_q  <= '0;
      opens_q <= 1'b0;
    end else if (beat_i) begin
      if (last) begin
        phase_q <= PhBracket;
        min_q   <= '0;
        sec_q   <= '0;
        hund_q  <= '0;
        fmin_q  <= '0;
        fsec_q  <= '0;
        fhund_q <= '0;
        seen_q  <= 1'b0;
        pos_q   <= '0;
        att_q   <= '0;
        toff_q  <= '0;
        opens_q <= 1'b0;
      end else begin
        phase_q <= phase_d;
        min_q   <= min_d;
        sec_q   <= sec_d;
        hund_q  <= hund_d;
        fmin_q  <= fmin_d;
        fsec_q  <= fsec_d;
        fhund_q <= fhund_d;
        seen_q  <= seen_d;
        pos_q   <= pos_d;
        att_q   <= att_d;
        toff_q  <= toff_d;
        opens_q <= opens_d;
      end
    end
  end

endmodule

@@ design/lrc_timestamp_line_parser.sv @@
// Top level: lyric line timestamp parser with millisecond result pipeline.
//
// Input channel: one line byte per beat (in_data_i.line_byte), with
// in_data_i.line_end set on the last byte of a line. Bytes at offset 510
// close the line on their own, so a line holds at most 511 bytes.
// Output channel: one result beat per line, carrying the first stamp in
// milliseconds, the stamp and metadata flags, the text offset and the
// line length.
// Throughput: one byte per cycle while in_stall_o is low; every byte is
// parsed in the cycle it is accepted by a small state update.
// Pipeline: after its last byte is accepted, a result passes the line
// summary register, the register of the three constant products (minutes,
// seconds, hundredths) and the output register holding their sum.
// Stall: each of the three stages fills while the ones after it are held,
// so bytes keep flowing while a result waits; in_stall_o rises only when
// the summary stage is full and cannot move on.
// Reset: clears the parser to the start of a line and empties all stages.
module lrc_timestamp_line_parser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  lrc_ts_pkg::lrc_ts_in_t  in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output lrc_ts_pkg::lrc_ts_out_t out_data_o
);

  localparam int unsigned PW = lrc_ts_pkg::PosW;

  typedef struct packed {
    logic [31:0]   pm;
    logic [31:0]   ps;
    logic [31:0]   pc;
    logic          has_stamp;
    logic          is_metadata;
    logic [PW-1:0] text_start;
    logic [PW-1:0] line_length;
  } lrc_ts_prod_t;

  logic                    beat;
  logic                    sum_valid;
  lrc_ts_pkg::lrc_ts_sum_t sum;

  logic                    s1_valid_q, s2_valid_q, out_valid_q;
  lrc_ts_pkg::lrc_ts_sum_t s1_q;
  lrc_ts_prod_t            s2_q, s2_d;
  lrc_ts_pkg::lrc_ts_out_t out_q, out_d;
  logic                    s1_ready, s2_ready, out_ready;

  // Stage readiness
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s2_ready   = !s2_valid_q || out_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;
  assign beat       = in_valid_i && s1_ready;

  lrc_ts_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (beat),
    .data_i      (in_data_i),
    .sum_valid_o (sum_valid),
    .sum_o       (sum)
  );

  // Constant products of the stamp parts
  always_comb begin
    s2_d.pm          = 32'(s1_q.min_part)  * lrc_ts_pkg::MsPerMin;
    s2_d.ps          = 32'(s1_q.sec_part)  * lrc_ts_pkg::MsPerSec;
    s2_d.pc          = 32'(s1_q.hund_part) * lrc_ts_pkg::MsPerHund;
    s2_d.has_stamp   = s1_q.has_stamp;
    s2_d.is_metadata = s1_q.is_metadata;
    s2_d.text_start  = s1_q.text_start;
    s2_d.line_length = s1_q.line_length;
  end

  // Final sum
  always_comb begin
    out_d.stamp_ms    = s2_q.pm + s2_q.ps + s2_q.pc;
    out_d.has_stamp   = s2_q.has_stamp;
    out_d.is_metadata = s2_q.is_metadata;
    out_d.text_start  = s2_q.text_start;
    out_d.line_length = s2_q.line_length;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready)  s1_valid_q  <= sum_valid;
      if (s2_ready)  s2_valid_q  <= s1_valid_q;
      if (out_ready) out_valid_q <= s2_valid_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s1_ready && sum_valid) s1_q  <= sum;
    if (s2_ready && s1_valid_q) s2_q <= s2_d;
    if (out_ready && s2_valid_q) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ design/lrc_ts_checker.sv @@
// Port-level checker for the lyric timestamp line parser, bound to the top level.
module lrc_ts_checker (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input lrc_ts_pkg::lrc_ts_out_t out_data_o
);

  // A held result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // No stamp means a zero time
  a_no_stamp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_stamp |-> out_data_o.stamp_ms == 32'd0)
    else $error("stamp time without a stamp");

  // A stamped line is never metadata
  a_stamp_not_meta: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.has_stamp |-> !out_data_o.is_metadata)
    else $error("stamped line flagged as metadata");

  // Text offset lies within the line
  a_text_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.text_start <= out_data_o.line_length &&
                    out_data_o.line_length != '0)
    else $error("text offset beyond line length");

endmodule

bind lrc_timestamp_line_parser lrc_ts_checker u_lrc_ts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
